[src/assert_macros.svh]
// Assertion macros for the top RTL file of the momentum update block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property checked on every rising edge, held off while reset is asserted
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Condition that must never be seen on a rising edge out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

[src/armu_pkg.sv]
// Package: widths, register indexes, opcodes and shared types of the momentum update block
package armu_pkg;

	localparam int DEPTH_DEF = 4096;
	localparam int FRAC_DEF  = 24;

	localparam int VAL_W  = 32;
	localparam int RATE_W = 31;
	localparam int ELEM_W = 12;

	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = $clog2(NUM_REGS);

	localparam logic [REG_IDX_W-1:0] REG_LAMBDA = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GAMMA  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_UP     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DOWN   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_FRMIN  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_FRMAX  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_CRMIN  = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_CRMAX  = 3'd7;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	localparam logic [RATE_W-1:0] U31_MAX = {RATE_W{1'b1}};

	// One row of the element store
	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic signed [VAL_W-1:0] mom;
		logic [RATE_W-1:0]       rate;
		logic signed [VAL_W-1:0] prev;
	} row_t;

	// Operand pair for the shared multiplier
	typedef struct packed {
		logic signed [VAL_W-1:0] a;
		logic signed [VAL_W-1:0] b;
	} mul_req_t;

	// Compare-subtract steps needed to fold an element index into a depth
	// that is not a power of two; none for a power of two.
	function automatic int mod_steps(input longint depth);
		int n;
		n = 0;
		if ((depth & (depth - 1)) == 0) begin
			return 0;
		end
		for (int k = 0; k < ELEM_W; k++) begin
			if ((depth << k) <= ((longint'(1) << ELEM_W) - 1)) begin
				n++;
			end
		end
		return n;
	endfunction

endpackage

[src/armu_if.sv]
// Interfaces: input item channel and result item channel
interface armu_in_if;
	import armu_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    op;
	logic [ELEM_W-1:0]       element;
	logic                    is_coupling;
	logic signed [VAL_W-1:0] target_freq;
	logic signed [VAL_W-1:0] model_freq;
	logic signed [VAL_W-1:0] load_value;
	logic [RATE_W-1:0]       load_rate;
	logic                    last;

	modport source (
		output valid, op, element, is_coupling, target_freq, model_freq,
			load_value, load_rate, last,
		input  ready
	);

	modport sink (
		input  valid, op, element, is_coupling, target_freq, model_freq,
			load_value, load_rate, last,
		output ready
	);
endinterface

interface armu_out_if;
	import armu_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [ELEM_W-1:0]       out_element;
	logic signed [VAL_W-1:0] new_value;
	logic signed [VAL_W-1:0] gradient;
	logic [RATE_W-1:0]       max_field_grad;
	logic [RATE_W-1:0]       max_coupling_grad;
	logic                    sweep_end;

	modport source (
		output valid, out_element, new_value, gradient, max_field_grad,
			max_coupling_grad, sweep_end,
		input  ready
	);

	modport sink (
		input  valid, out_element, new_value, gradient, max_field_grad,
			max_coupling_grad, sweep_end,
		output ready
	);
endinterface

[src/adaptive_rate_momentum_update.sv]
// Update item: accepted, its element index folded when DEPTH is not a power of two, the
// store row read, the seven-step schedule run around the single two-stage multiplier, the
// result pushed; load item: accepted, index folded likewise, row written and pushed. One
// item at a time: a new item is taken only once the last has been pushed. The store read is
// registered. Reset clears the sequencer, output valid, configuration registers and maxima;
// store rows are undefined until loaded.
`include "assert_macros.svh"

module adaptive_rate_momentum_update #(
	parameter int DEPTH     = armu_pkg::DEPTH_DEF,
	parameter int FRAC_BITS = armu_pkg::FRAC_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	armu_in_if.sink                         in_ch,
	armu_out_if.source                      out_ch,
	input  logic                            wr_en,
	input  logic [armu_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [armu_pkg::RATE_W-1:0]     wr_data
);
	import armu_pkg::*;

	localparam int AW        = $clog2(DEPTH);
	localparam int RW        = 2 * VAL_W - FRAC_BITS;
	localparam int SW        = RW + 2;
	localparam int MOD_STEPS = mod_steps(longint'(DEPTH));
	localparam int KW        = $clog2(ELEM_W);
	localparam logic [KW-1:0] K_INIT = KW'(MOD_STEPS > 0 ? MOD_STEPS - 1 : 0);

	localparam logic [RATE_W-1:0]       RATE_ONE = RATE_W'(1) << FRAC_BITS;
	localparam logic signed [VAL_W-1:0] VAL_ONE  = VAL_W'(1) << FRAC_BITS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MOD  = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_CALC = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam logic [2:0] STEP_LAMBDA = 3'd0;
	localparam logic [2:0] STEP_GAMMA  = 3'd1;
	localparam logic [2:0] STEP_GRAD   = 3'd2;
	localparam logic [2:0] STEP_RATEG  = 3'd3;
	localparam logic [2:0] STEP_ADAPT  = 3'd4;
	localparam logic [2:0] STEP_MOM    = 3'd5;
	localparam logic [2:0] STEP_LAST   = 3'd6;

	function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SW-1:0] v);
		if (v[SW-1:VAL_W-1] == '0 || v[SW-1:VAL_W-1] == '1) begin
			return v[VAL_W-1:0];
		end
		return v[SW-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
	endfunction

	logic [2:0] state_q;
	logic [2:0] step_q;
	logic [KW-1:0] k_q;
	logic [ELEM_W-1:0] r_q;

	logic [RATE_W-1:0] cfg_q [NUM_REGS];

	logic                    op_q;
	logic [ELEM_W-1:0]       elem_q;
	logic                    coup_q;
	logic signed [VAL_W-1:0] tgt_q;
	logic signed [VAL_W-1:0] mdl_q;
	logic signed [VAL_W-1:0] ldv_q;
	logic [RATE_W-1:0]       ldr_q;
	logic                    last_q;

	logic signed [RW-1:0]    t2_q;
	logic signed [VAL_W-1:0] grad_q;
	logic                    adapt_q;
	logic signed [VAL_W-1:0] mom_q;
	logic signed [VAL_W-1:0] val_q;
	logic [RATE_W-1:0]       rate_q;
	logic [RATE_W-1:0]       fmax_q;
	logic [RATE_W-1:0]       cmax_q;

	logic                    out_vld_q;
	logic [ELEM_W-1:0]       oel_q;
	logic signed [VAL_W-1:0] oval_q;
	logic signed [VAL_W-1:0] ograd_q;
	logic [RATE_W-1:0]       ofmax_q;
	logic [RATE_W-1:0]       ocmax_q;
	logic                    oend_q;

	logic [AW-1:0]    idx;
	logic             rd_en;
	logic             push;
	row_t             rd_row;
	row_t             wr_row;
	mul_req_t         mul_req;
	logic signed [RW-1:0] mul_res;

	logic [RATE_W-1:0] rmin;
	logic [RATE_W-1:0] rmax;
	logic              sign_nz;
	logic              same_sign;
	logic              flip_sign;
	logic [RATE_W-1:0] rate_mul;
	logic [RATE_W-1:0] rate_adj;
	logic [RATE_W-1:0] rate_hi;
	logic [RATE_W-1:0] rate_new;
	logic [VAL_W-1:0]  grad_neg;
	logic [RATE_W-1:0] mag;
	logic              upd;
	logic [RATE_W-1:0] fmax_new;
	logic [RATE_W-1:0] cmax_new;
	logic [31:0]       dk;

	assign idx   = AW'(r_q);
	assign rd_en = (state_q == ST_RD);
	assign push  = (state_q == ST_DONE) && (!out_vld_q || out_ch.ready);
	assign upd   = (op_q == OP_UPDATE);

	assign in_ch.ready = (state_q == ST_IDLE);

	assign out_ch.valid             = out_vld_q;
	assign out_ch.out_element       = oel_q;
	assign out_ch.new_value         = oval_q;
	assign out_ch.gradient          = ograd_q;
	assign out_ch.max_field_grad    = ofmax_q;
	assign out_ch.max_coupling_grad = ocmax_q;
	assign out_ch.sweep_end         = oend_q;

	armu_store #(
		.WIDTH ($bits(row_t)),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (push),
		.wr_addr (idx),
		.wr_data (wr_row),
		.rd_en   (rd_en),
		.rd_addr (idx),
		.rd_data (rd_row)
	);

	armu_mul #(
		.FRAC_BITS (FRAC_BITS)
	) u_mul (
		.clk    (clk),
		.req    (mul_req),
		.res_s2 (mul_res)
	);

	// class bounds and sign test
	always_comb begin
		rmin      = coup_q ? cfg_q[REG_CRMIN] : cfg_q[REG_FRMIN];
		rmax      = coup_q ? cfg_q[REG_CRMAX] : cfg_q[REG_FRMAX];
		sign_nz   = (rd_row.prev != '0) && (grad_q != '0);
		same_sign = sign_nz && (rd_row.prev[VAL_W-1] == grad_q[VAL_W-1]);
		flip_sign = sign_nz && !same_sign;
	end

	// operand selection for the shared multiplier
	always_comb begin
		mul_req.a = '0;
		mul_req.b = '0;
		case (step_q)
			STEP_LAMBDA: begin
				mul_req.a = {1'b0, cfg_q[REG_LAMBDA]};
				mul_req.b = rd_row.value;
			end
			STEP_GAMMA: begin
				mul_req.a = {1'b0, cfg_q[REG_GAMMA]};
				mul_req.b = rd_row.mom;
			end
			STEP_RATEG: begin
				mul_req.a = {1'b0, rd_row.rate};
				mul_req.b = grad_q;
			end
			STEP_ADAPT: begin
				mul_req.a = {1'b0, same_sign ? cfg_q[REG_UP] : cfg_q[REG_DOWN]};
				mul_req.b = {1'b0, rd_row.rate};
			end
			default: begin
				mul_req.a = '0;
				mul_req.b = '0;
			end
		endcase
	end

	// rate saturation and clamping, max first, then min
	always_comb begin
		rate_mul = (mul_res[RW-1:RATE_W] != '0) ? U31_MAX : mul_res[RATE_W-1:0];
		rate_adj = adapt_q ? rate_mul : rd_row.rate;
		rate_hi  = (rate_adj > rmax) ? rmax : rate_adj;
		rate_new = (rate_hi < rmin) ? rmin : rate_hi;
	end

	// sweep maxima including the item in hand
	always_comb begin
		grad_neg = -grad_q;
		if (!grad_q[VAL_W-1]) begin
			mag = grad_q[RATE_W-1:0];
		end else if (grad_q == {1'b1, {(VAL_W-1){1'b0}}}) begin
			mag = U31_MAX;
		end else begin
			mag = grad_neg[RATE_W-1:0];
		end
		fmax_new = (upd && !coup_q && mag > fmax_q) ? mag : fmax_q;
		cmax_new = (upd && coup_q && mag > cmax_q) ? mag : cmax_q;
	end

	always_comb begin
		if (upd) begin
			wr_row.value = val_q;
			wr_row.mom   = mom_q;
			wr_row.rate  = rate_q;
			wr_row.prev  = grad_q;
		end else begin
			wr_row.value = ldv_q;
			wr_row.mom   = '0;
			wr_row.rate  = ldr_q;
			wr_row.prev  = VAL_ONE;
		end
	end

	assign dk = 32'(DEPTH) << k_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_LAMBDA] <= '0;
			cfg_q[REG_GAMMA]  <= '0;
			cfg_q[REG_UP]     <= RATE_ONE;
			cfg_q[REG_DOWN]   <= RATE_ONE;
			cfg_q[REG_FRMIN]  <= '0;
			cfg_q[REG_FRMAX]  <= U31_MAX;
			cfg_q[REG_CRMIN]  <= '0;
			cfg_q[REG_CRMAX]  <= U31_MAX;
		end else if (wr_en) begin
			cfg_q[wr_index] <= wr_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= STEP_LAMBDA;
			k_q       <= K_INIT;
			fmax_q    <= '0;
			cmax_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (push) begin
				out_vld_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						k_q <= K_INIT;
						if (MOD_STEPS > 0) begin
							state_q <= ST_MOD;
						end else if (in_ch.op == OP_UPDATE) begin
							state_q <= ST_RD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_MOD: begin
					if (k_q == '0) begin
						state_q <= upd ? ST_RD : ST_DONE;
					end else begin
						k_q <= k_q - KW'(1);
					end
				end
				ST_RD: begin
					step_q  <= STEP_LAMBDA;
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (step_q == STEP_LAST) begin
						step_q  <= STEP_LAMBDA;
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_DONE: begin
					if (push) begin
						fmax_q  <= last_q ? '0 : fmax_new;
						cmax_q  <= last_q ? '0 : cmax_new;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			op_q   <= in_ch.op;
			elem_q <= in_ch.element;
			coup_q <= in_ch.is_coupling;
			tgt_q  <= in_ch.target_freq;
			mdl_q  <= in_ch.model_freq;
			ldv_q  <= in_ch.load_value;
			ldr_q  <= in_ch.load_rate;
			last_q <= in_ch.last;
			r_q    <= in_ch.element;
		end
		// fold the index one compare-subtract a cycle
		if (state_q == ST_MOD && 32'(r_q) >= dk) begin
			r_q <= r_q - ELEM_W'(dk);
		end
		if (state_q == ST_CALC) begin
			case (step_q)
				STEP_GRAD: begin
					grad_q <= sat32(SW'(tgt_q) - SW'(mdl_q) - SW'(mul_res) - SW'(mul_res));
				end
				STEP_RATEG: begin
					t2_q <= mul_res;
				end
				STEP_ADAPT: begin
					adapt_q <= (same_sign && rd_row.rate < rmax) ||
						(flip_sign && rd_row.rate > rmin);
				end
				STEP_MOM: begin
					mom_q <= sat32(SW'(t2_q) + SW'(mul_res));
				end
				STEP_LAST: begin
					val_q  <= sat32(SW'($signed(rd_row.value)) + SW'(mom_q));
					rate_q <= rate_new;
				end
				default: begin
				end
			endcase
		end
		if (push) begin
			oel_q   <= elem_q;
			oval_q  <= upd ? val_q : ldv_q;
			ograd_q <= upd ? grad_q : '0;
			ofmax_q <= fmax_new;
			ocmax_q <= cmax_new;
			oend_q  <= last_q;
		end
	end

	`ASSERT_PROP(a_busy_after_accept, clk, arst_n, (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
	`ASSERT_PROP(a_sweep_clears, clk, arst_n, (push && last_q) |=> (fmax_q == '0 && cmax_q == '0))
	`ASSERT_PROP(a_load_zero_grad, clk, arst_n, (push && !upd) |=> (out_ch.gradient == '0))
	`ASSERT_NEVER(a_push_while_busy, clk, arst_n, push && in_ch.ready)

endmodule

[src/armu_store.sv]
// Element store: one write port, one read port with registered read data
module armu_store #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// hold the read word until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

[src/armu_mul.sv]
// Shared multiplier: signed 32x32 product, then round to nearest (ties up) and drop fraction bits
module armu_mul #(
	parameter int FRAC_BITS = armu_pkg::FRAC_DEF,
	localparam int RW = 2 * armu_pkg::VAL_W - FRAC_BITS
) (
	input  logic                 clk,
	input  armu_pkg::mul_req_t   req,
	output logic signed [RW-1:0] res_s2
);
	import armu_pkg::*;

	localparam logic signed [2*VAL_W-1:0] HALF = (2*VAL_W)'(1) <<< (FRAC_BITS - 1);

	logic signed [2*VAL_W-1:0] prod_s1;
	logic signed [2*VAL_W-1:0] rnd_sum;

	always_ff @(posedge clk) begin
		prod_s1 <= req.a * req.b;
	end

	assign rnd_sum = prod_s1 + HALF;

	always_ff @(posedge clk) begin
		res_s2 <= RW'(rnd_sum >>> FRAC_BITS);
	end
endmodule
